// File: hdl/stqb_pkg.sv
package stqb_pkg;

    // defaults for the top level parameters
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 64;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 9;
    localparam int FILL_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // result beat: read_value, queue_fill, stack_fill, padded to whole bytes
    localparam int M_FIELDS_W = VALUE_W + 2 * FILL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE  = 3'd0,
        ACT_PUSH     = 3'd1,
        ACT_DEQUEUE  = 3'd2,
        ACT_POP      = 3'd3,
        ACT_TRANSFER = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XFER,
        ST_EMIT
    } state_t;

endpackage

// File: hdl/stqb_ram.sv
module stqb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/stack_to_queue_transfer_buffer.sv
// stack and queue transfer buffer: a circular queue and a stack of opaque words, each held
// in its own single-port-write, registered-read memory of DEPTH entries. every input beat
// carries one command in s_tuser (enqueue, push, dequeue, pop, transfer) and gives exactly
// one result beat with the removed word, a status (ok, full so dropped, empty) and both
// fills after the command. enqueue, push, dequeue and pop do the memory access in the
// accept cycle, and the emit state loads the result register once it is free or draining.
// transfer empties the stack: the stack memory gives one word per cycle through its read
// port and each word is written to the queue the cycle after.
// words that meet a full queue during a transfer are dropped and flagged. one command is in
// work at a time; a new beat is taken once the previous one has reached the result register,
// even while that result still waits on m_tready. capacity (cfg_wr_data) applies to both
// structures; 0 acts as 1, values above DEPTH act as DEPTH, and lowering it below a fill
// loses nothing. the memories have no reset or clearing pass; reset clears the pointers,
// counts and flags and sets capacity to 256, so the block is ready right after reset.
module stack_to_queue_transfer_buffer #(
    parameter int DEPTH      = stqb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = stqb_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // capacity register
    input  logic                           cfg_wr_en,
    input  logic [stqb_pkg::CAP_W-1:0]     cfg_wr_data,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stqb_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  logic [stqb_pkg::ACTION_W-1:0]  s_tuser,   // action
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stqb_pkg::M_TDATA_W-1:0] m_tdata,   // read_value, queue_fill, stack_fill
    output logic [stqb_pkg::STATUS_W-1:0]  m_tuser    // status
);

    import stqb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // next slot of the circular queue, wraps at DEPTH
    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // control state
    state_t          state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [AW-1:0]   q_head_reg, q_head_next;
    logic [AW-1:0]   q_tail_reg, q_tail_next;
    logic [CW-1:0]   q_count_reg, q_count_next;
    logic [CW-1:0]   s_count_reg, s_count_next;
    logic            pend_reg, pend_next;      // stack word in read data waits for the queue
    logic            m_valid_reg, m_valid_next;

    // payload of the command in work
    action_t         op_reg, op_next;
    status_t         status_reg, status_next;

    // result register
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    status_t            m_status_reg, m_status_next;
    logic [FILL_W-1:0]  m_qfill_reg, m_qfill_next;
    logic [FILL_W-1:0]  m_sfill_reg, m_sfill_next;
    logic               m_load;

    // memory ports
    logic                  q_we, q_re, s_we, s_re;
    logic [AW-1:0]         q_waddr, q_raddr, s_waddr, s_raddr;
    logic [DATA_WIDTH-1:0] q_wdata, q_rdata, s_wdata, s_rdata;

    // capacity clamp and full flags
    logic [LW-1:0]   limit;
    logic [LW-1:0]   cap_wide;
    logic            q_full, s_full;
    logic [CW-1:0]   s_count_dec;

    always_comb begin
        cap_wide = LW'(cap_reg);
        if (cap_reg == '0) begin
            limit = LW'(1);
        end else if (cap_wide > LW'(DEPTH)) begin
            limit = LW'(DEPTH);
        end else begin
            limit = cap_wide;
        end
    end

    assign q_full      = LW'(q_count_reg) >= limit;
    assign s_full      = LW'(s_count_reg) >= limit;
    assign s_count_dec = s_count_reg - 1'b1;

    // queue memory: written by enqueue or by transfer, read by dequeue
    stqb_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_queue_ram (
        .clk  (aclk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .re   (q_re),
        .raddr(q_raddr),
        .rdata(q_rdata)
    );

    // stack memory: written by push, read by pop and by transfer
    stqb_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_stack_ram (
        .clk  (aclk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .re   (s_re),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // fixed memory addressing, only the enables depend on the command
    assign q_waddr = q_tail_reg;
    assign q_raddr = q_head_reg;
    assign s_waddr = s_count_reg[AW-1:0];
    assign s_raddr = s_count_dec[AW-1:0];
    assign s_wdata = s_tdata[DATA_WIDTH-1:0];
    // during a transfer the queue takes the word just read from the stack
    assign q_wdata = (state_reg == ST_XFER) ? s_rdata : s_tdata[DATA_WIDTH-1:0];

    always_comb begin
        state_next   = state_reg;
        q_head_next  = q_head_reg;
        q_tail_next  = q_tail_reg;
        q_count_next = q_count_reg;
        s_count_next = s_count_reg;
        pend_next    = pend_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        q_we         = 1'b0;
        q_re         = 1'b0;
        s_we         = 1'b0;
        s_re         = 1'b0;
        m_load       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = action_t'(s_tuser);
                    status_next = STATUS_OK;
                    state_next  = ST_EMIT;
                    case (action_t'(s_tuser))
                        ACT_ENQUEUE: begin
                            if (q_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                q_we         = 1'b1;
                                q_tail_next  = wrap_next(q_tail_reg);
                                q_count_next = q_count_reg + 1'b1;
                            end
                        end
                        ACT_PUSH: begin
                            if (s_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                s_we         = 1'b1;
                                s_count_next = s_count_reg + 1'b1;
                            end
                        end
                        ACT_DEQUEUE: begin
                            if (q_count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                q_re         = 1'b1;
                                q_head_next  = wrap_next(q_head_reg);
                                q_count_next = q_count_reg - 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (s_count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                s_re         = 1'b1;
                                s_count_next = s_count_dec;
                            end
                        end
                        ACT_TRANSFER: begin
                            pend_next  = 1'b0;
                            state_next = ST_XFER;
                        end
                        default: begin
                            // unknown command: no change, ok result
                        end
                    endcase
                end
            end

            ST_XFER: begin
                // put the word read last cycle into the queue
                if (pend_reg) begin
                    if (q_full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        q_we         = 1'b1;
                        q_tail_next  = wrap_next(q_tail_reg);
                        q_count_next = q_count_reg + 1'b1;
                    end
                end
                // and read the next stack top
                if (s_count_reg != '0) begin
                    s_re         = 1'b1;
                    s_count_next = s_count_dec;
                    pend_next    = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register contents
    always_comb begin
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_qfill_next  = m_qfill_reg;
        m_sfill_next  = m_sfill_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        if (m_load) begin
            m_valid_next  = 1'b1;
            m_status_next = status_reg;
            m_qfill_next  = FILL_W'(q_count_reg);
            m_sfill_next  = FILL_W'(s_count_reg);
            m_value_next  = '0;
            if (status_reg == STATUS_OK) begin
                if (op_reg == ACT_DEQUEUE) begin
                    m_value_next = VALUE_W'(q_rdata);
                end else if (op_reg == ACT_POP) begin
                    m_value_next = VALUE_W'(s_rdata);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
            s_count_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            q_head_reg  <= q_head_next;
            q_tail_reg  <= q_tail_next;
            q_count_reg <= q_count_next;
            s_count_reg <= s_count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_qfill_reg  <= m_qfill_next;
        m_sfill_reg  <= m_sfill_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_sfill_reg, m_qfill_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

    // fills never pass the memory depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_count_reg <= CW'(DEPTH))
        else $error("stack count above depth");

    // a transfer walks down the stack one entry per cycle
    a_xfer_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XFER && s_count_reg != '0) |=>
            s_count_reg == $past(s_count_reg) - 1'b1)
        else $error("transfer did not step the stack");

    // a finished transfer leaves the stack empty
    a_xfer_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && op_reg == ACT_TRANSFER) |-> s_count_reg == '0)
        else $error("stack not empty after transfer");

    // a result is loaded only when the output slot is free or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

endmodule
